@@ rtl/core/ucss_pkg.sv @@
// ----------------------------------------------------------------------------
// ucss_pkg
// Shared types, constants and the segment decoder of the up/down counter
// with multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
package ucss_pkg;

  localparam int unsigned COUNT_W     = 27;
  localparam int unsigned TICKS_W     = 8;
  localparam int unsigned BCD_DIGITS  = 8;
  localparam int unsigned CFG_DATA_W  = 27;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 48;

  localparam logic [COUNT_W-1:0] COUNT_CEILING = 27'd99999999;
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 27'd65534;
  localparam logic [TICKS_W-1:0] TICKS_RESET   = 8'd10;
  localparam logic [TICKS_W-1:0] HOLD_MAX      = 8'd255;
  localparam logic [7:0]         SEL_BASE      = 8'hfe;
  localparam logic [7:0]         SEL_OFF       = 8'hff;
  localparam logic [7:0]         SEG_BLANK     = 8'h00;

  // COUNT_RESET in BCD, element 0 holds the least significant digit
  localparam logic [BCD_DIGITS-1:0][3:0] COUNT_RESET_BCD =
    {4'd0, 4'd0, 4'd0, 4'd6, 4'd5, 4'd5, 4'd3, 4'd4};

  typedef enum logic [0:0] {
    CFG_DEBOUNCE_TICKS = 1'b0,
    CFG_MAX_COUNT      = 1'b1
  } cfg_reg_e;

  // ripple control handed along the digit row
  typedef struct packed {
    logic step;  // apply one unit at this digit
    logic down;  // 1 = decrement, 0 = increment
  } bcd_ctrl_t;

  function automatic logic [7:0] seg_decode(logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/core/ucss_debounce.sv @@
// ----------------------------------------------------------------------------
// ucss_debounce
// Hold counter for one key: fires once after the programmed number of
// pressed ticks, then waits for release.
// ----------------------------------------------------------------------------
module ucss_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic                        pressed_i,
  input  logic [ucss_pkg::TICKS_W-1:0] ticks_i,
  output logic                        act_o
);
  import ucss_pkg::*;

  logic [TICKS_W-1:0] hold_q, hold_d, hold_inc;
  logic               wait_q, wait_d;

  assign hold_inc = (hold_q == HOLD_MAX) ? HOLD_MAX : hold_q + 8'd1;

  always_comb begin
    hold_d = hold_q;
    wait_d = wait_q;
    act_o  = 1'b0;
    if (tick_i) begin
      if (!pressed_i) begin
        hold_d = '0;
        wait_d = 1'b0;
      end else if (!wait_q) begin
        // a threshold of zero behaves like one
        if (hold_inc >= ticks_i) begin
          hold_d = '0;
          wait_d = 1'b1;
          act_o  = 1'b1;
        end else begin
          hold_d = hold_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      wait_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      wait_q <= wait_d;
    end
  end

endmodule

@@ rtl/core/ucss_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// ucss_bcd_cell
// One decimal digit of the count; takes a carry or borrow from the lower
// digit and passes one on to the next.
// ----------------------------------------------------------------------------
module ucss_bcd_cell #(
  parameter logic [3:0] RESET_DIGIT = 4'd0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ucss_pkg::bcd_ctrl_t  ctrl_i,
  output ucss_pkg::bcd_ctrl_t  ctrl_o,
  output logic [3:0]           digit_next_o
);
  import ucss_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic       wrap;

  assign wrap = ctrl_i.down ? (digit_q == 4'd0) : (digit_q == 4'd9);

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.step) begin
      if (ctrl_i.down) begin
        digit_d = wrap ? 4'd9 : digit_q - 4'd1;
      end else begin
        digit_d = wrap ? 4'd0 : digit_q + 4'd1;
      end
    end
  end

  assign ctrl_o.step   = ctrl_i.step & wrap;
  assign ctrl_o.down   = ctrl_i.down;
  assign digit_next_o  = digit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= RESET_DIGIT;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ rtl/core/updown_counter_seven_segment_scan.sv @@
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan
// Debounced up/down counter kept as a row of BCD digit cells, with an
// eight-position one-cold scan of the seven-segment display.
// ----------------------------------------------------------------------------
// Each input transaction's result is registered in the output stage before it reaches the master side.
// Throughput: one transaction per cycle while the skid entry is free; the decimal
//   carry ripples combinationally through the eight digit cells.
// A two-entry output stage (register plus skid) keeps input ready high
//   while one result waits on a stalled output.
// Reset: count 65534, scan position 0, segments blank, selects all off,
//   debounce 10 ticks, limit 99999999; no clearing pass.
module updown_counter_seven_segment_scan #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // bit 0 up_key, bit 1 down_key, bit 2 scan_strobe, rest zero
  input  logic [ucss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] segment_code, [15:8] digit_select, [42:16] count_value, rest zero
  output logic [ucss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [ucss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ucss_pkg::*;

  localparam logic [2:0] LAST_POS = 3'(DIGITS - 1);

  logic               in_fire;
  logic               up_key, down_key, scan_strobe;
  logic               up_act, down_act, up_eff, down_eff;
  logic [TICKS_W-1:0] ticks_q;
  logic [COUNT_W-1:0] limit_q, count_q, count_d;
  logic [2:0]         pos_q, pos_d, place;
  logic [7:0]         seg_q, seg_d, sel_q, sel_d;

  bcd_ctrl_t                     chain [BCD_DIGITS+1];
  logic [BCD_DIGITS-1:0][3:0]    bcd_next;

  logic [OUT_DATA_W-1:0] result;
  logic [OUT_DATA_W-1:0] out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;

  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign up_key      = s_axis_tdata[0];
  assign down_key    = s_axis_tdata[1];
  assign scan_strobe = s_axis_tdata[2];

  // configuration; the limit is clamped to eight decimal digits on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      limit_q <= COUNT_CEILING;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS: ticks_q <= cfg_data_i[TICKS_W-1:0];
        CFG_MAX_COUNT:
          limit_q <= (cfg_data_i > COUNT_CEILING) ? COUNT_CEILING : cfg_data_i;
        default: ;
      endcase
    end
  end

  ucss_debounce u_up_deb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (in_fire),
    .pressed_i (up_key),
    .ticks_i   (ticks_q),
    .act_o     (up_act)
  );

  ucss_debounce u_down_deb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (in_fire),
    .pressed_i (down_key),
    .ticks_i   (ticks_q),
    .act_o     (down_act)
  );

  // up is applied first, so down may undo an increment from zero
  assign up_eff   = up_act & (count_q < limit_q);
  assign down_eff = down_act & ((count_q != '0) | up_eff);

  always_comb begin
    count_d = count_q;
    if (up_eff && !down_eff) begin
      count_d = count_q + 27'd1;
    end else if (down_eff && !up_eff) begin
      count_d = count_q - 27'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  // decimal copy of the count, one cell per digit
  assign chain[0].step = up_eff ^ down_eff;
  assign chain[0].down = down_eff;

  for (genvar i = 0; i < BCD_DIGITS; i++) begin : g_cell
    ucss_bcd_cell #(
      .RESET_DIGIT (COUNT_RESET_BCD[i])
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (chain[i]),
      .ctrl_o       (chain[i+1]),
      .digit_next_o (bcd_next[i])
    );
  end

  // scan: position k shows decimal place DIGITS-1-k
  assign place = LAST_POS - pos_q;

  always_comb begin
    pos_d = pos_q;
    seg_d = seg_q;
    sel_d = sel_q;
    if (in_fire && scan_strobe) begin
      seg_d = seg_decode(bcd_next[place]);
      sel_d = ~(~SEL_BASE << pos_q);
      pos_d = (pos_q >= LAST_POS) ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      seg_q <= SEG_BLANK;
      sel_q <= SEL_OFF;
    end else begin
      pos_q <= pos_d;
      seg_q <= seg_d;
      sel_q <= sel_d;
    end
  end

  assign result = {5'd0, count_d, sel_d, seg_d};

  // output register with skid entry
  assign s_axis_tready = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced up/down counter with seven-segment
// scan. Key and scan ticks go in on the input stream. A tracker predicts each
// segment, select and count result and compares it with the output stream.
// The run covers several register settings and both sides idling or stalling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucss_pkg::*;

  localparam int unsigned        TIMEOUT_CYCLES = 5000;
  localparam logic [COUNT_W-1:0] TOP_COUNT      = 27'd99999999;
  localparam logic [COUNT_W-1:0] START_COUNT    = 27'd65534;
  localparam logic [COUNT_W-1:0] WIDEST_LIMIT   = '1;
  localparam logic [7:0]         SEG_PATTERN [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef enum int unsigned {
    KEY_UP   = 0,
    KEY_DOWN = 1
  } key_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         select;
    logic [7:0]         segments;
  } display_t;

  class count_display_tracker;
    logic [TICKS_W-1:0] debounce_ticks;
    logic [COUNT_W-1:0] max_count;
    logic [COUNT_W-1:0] count;
    logic [2:0]         digit_pos;
    logic [TICKS_W-1:0] hold [2];
    bit                 waiting [2];
    logic [7:0]         segments;
    logic [7:0]         select;
    display_t           pending [$];
    int unsigned        checked;
    int unsigned        failures;

    function new();
      debounce_ticks = 8'd10;
      max_count      = TOP_COUNT;
      count          = START_COUNT;
      digit_pos      = '0;
      hold[KEY_UP]   = '0;
      hold[KEY_DOWN] = '0;
      waiting[KEY_UP]   = 1'b0;
      waiting[KEY_DOWN] = 1'b0;
      segments       = 8'h00;
      select         = 8'hff;
      checked        = 0;
      failures       = 0;
    endfunction

    // one press acts once, then the key must be released
    function bit key_fires(key_e key, bit pressed);
      if (!pressed) begin
        hold[key]    = '0;
        waiting[key] = 1'b0;
        return 1'b0;
      end
      if (waiting[key]) return 1'b0;
      if (hold[key] != 8'hff) hold[key]++;
      if (hold[key] >= debounce_ticks) begin
        hold[key]    = '0;
        waiting[key] = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_tick(logic [2:0] keys);
      logic [COUNT_W-1:0] limit;
      logic [COUNT_W-1:0] scaled;
      display_t           d;
      limit = (max_count > TOP_COUNT) ? TOP_COUNT : max_count;
      if (key_fires(KEY_UP, keys[0]) && count < limit) count++;
      if (key_fires(KEY_DOWN, keys[1]) && count != '0) count--;
      if (keys[2]) begin
        // position 0 shows the most significant decimal place
        scaled = count;
        repeat (7 - digit_pos) scaled = scaled / 10;
        segments  = SEG_PATTERN[scaled % 10];
        select    = ~(8'd1 << digit_pos);
        digit_pos = digit_pos + 3'd1;
      end
      d.segments = segments;
      d.select   = select;
      d.count    = count;
      pending.push_back(d);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_display(logic [OUT_DATA_W-1:0] data);
      display_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting: %h", data);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_field("segment_code", 32'(want.segments), 32'(data[7:0]));
      compare_field("digit_select", 32'(want.select), 32'(data[15:8]));
      compare_field("count_value", 32'(want.count), 32'(data[42:16]));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  count_display_tracker tracker = new();

  int unsigned sender_idle_pct    = 0;
  int unsigned stall_pct          = 0;
  int unsigned long_stall_request = 0;
  int unsigned accepted_ticks     = 0;
  int unsigned settings_used      = 0;
  int unsigned quiet_cycles       = 0;

  updown_counter_seven_segment_scan #(
    .DIGITS(8)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // transaction monitor, scoreboard hookup and watchdog
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tracker.note_tick(s_axis_tdata[2:0]);
      accepted_ticks++;
    end
    if (m_axis_tvalid && m_axis_tready) tracker.check_display(m_axis_tdata);
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= TIMEOUT_CYCLES) begin
      $display("updown_counter_seven_segment_scan verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stalls plus an occasional long hold-off
  initial begin
    int unsigned held_off;
    held_off = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_request != 0) begin
        held_off = long_stall_request;
        long_stall_request = 0;
      end
      if (held_off != 0) begin
        held_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  task automatic send_tick(input logic [2:0] keys);
    if (sender_idle_pct != 0) begin
      while ($urandom_range(99, 0) < sender_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, keys};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait for every predicted result, then a little beyond the latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic configure(input logic [TICKS_W-1:0] ticks, input logic [COUNT_W-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEBOUNCE_TICKS;
    cfg_data_i  <= CFG_DATA_W'(ticks);
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_COUNT;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.debounce_ticks = ticks;
    tracker.max_count      = limit;
    settings_used++;
  endtask

  // mostly whole presses sized around the debounce count, some noise ticks
  task automatic key_traffic(input int unsigned n_ticks);
    int unsigned done_ticks;
    int unsigned hold_len;
    int unsigned base;
    logic [1:0]  keys;
    done_ticks = 0;
    base = (tracker.debounce_ticks == 0) ? 1 : tracker.debounce_ticks;
    while (done_ticks < n_ticks) begin
      if ($urandom_range(9, 0) < 2) begin
        send_tick(3'($urandom));
        done_ticks++;
      end else begin
        keys = 2'($urandom_range(3, 1));
        // some presses let go before the debounce count is reached
        hold_len = ($urandom_range(5, 0) == 0) ? $urandom_range(base, 1)
                                                : base + $urandom_range(2, 0);
        repeat (hold_len) begin
          send_tick({1'($urandom), keys});
          done_ticks++;
        end
        repeat ($urandom_range(2, 1)) begin
          send_tick({1'($urandom), 2'b00});
          done_ticks++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_DEBOUNCE_TICKS;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: blank before any strobe, full scan with wrap, one press
    send_tick(3'b000);
    repeat (9) send_tick(3'b100);
    for (int i = 0; i < 11; i++) send_tick({i[0], 2'b01});
    send_tick(3'b100);
    settle();

    // zero debounce behaves as one; limit above the decimal ceiling
    configure(8'd0, WIDEST_LIMIT);
    send_tick(3'b001);
    send_tick(3'b101);
    send_tick(3'b000);
    send_tick(3'b010);
    send_tick(3'b111);
    send_tick(3'b100);
    settle();

    // limit lowered under the count: up is ignored, down still steps
    configure(8'd1, tracker.count - 27'd2);
    sender_idle_pct = 22;
    stall_pct       = 22;
    key_traffic(30);
    settle();

    // back to back down presses, each released after one tick
    configure(8'd1, TOP_COUNT);
    sender_idle_pct = 0;
    stall_pct       = 0;
    repeat (25) begin
      send_tick({1'($urandom), 2'b10});
      send_tick({1'($urandom), 2'b00});
    end
    settle();

    configure(8'd0, '0);
    sender_idle_pct = 87;
    key_traffic(50);
    settle();

    configure(8'd3, WIDEST_LIMIT);
    sender_idle_pct = 0;
    stall_pct       = 87;
    key_traffic(70);
    settle();

    // limit just above the count so up presses hit saturation
    configure(8'd2, tracker.count + 27'd4);
    sender_idle_pct = 22;
    stall_pct       = 22;
    key_traffic(70);
    settle();

    // longest debounce, with the output held off while input keeps coming
    configure(8'd255, TOP_COUNT);
    sender_idle_pct    = 0;
    stall_pct          = 0;
    long_stall_request = 400;
    key_traffic(150);
    settle();

    configure(8'd1, (tracker.count != '0) ? tracker.count - 27'd1 : '0);
    sender_idle_pct = 87;
    key_traffic(40);
    settle();

    $display("%0d ticks accepted, %0d results checked across %0d register settings",
             accepted_ticks, tracker.checked, settings_used);
    $display("count stepped both ways, limits at zero, below the count, at saturation and over ceiling");
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("updown_counter_seven_segment_scan verification clean");
    end else begin
      $display("updown_counter_seven_segment_scan verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ucss_pkg.sv
rtl/core/ucss_debounce.sv
rtl/core/ucss_bcd_cell.sv
rtl/core/updown_counter_seven_segment_scan.sv
tb/sv/tb.sv
